>>> rtl/tvce_pkg.sv
// ----------------------------------------------------------------------------
// tvce_pkg
// Shared widths, constants, command codes and the arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tvce_pkg;

  localparam int unsigned FracBits    = 8;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned AtanEntries = 24;

  localparam int unsigned CoordW = 24;
  localparam int unsigned AngW   = 17;
  localparam int unsigned HeadW  = 16;
  localparam int unsigned PixW   = 16;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned RotW   = 33;
  localparam int unsigned ZW     = 26;
  localparam int unsigned ItW    = 5;
  localparam int unsigned ProdW  = CoordW + RotW;

  localparam logic signed [RotW-1:0] CordicGain = 33'sd652032874;

  localparam logic [HeadW-1:0] QuarterTurn = 16'd11520;
  localparam logic [HeadW-1:0] FarLimit    = 16'd34560;
  localparam logic [HeadW-1:0] FullTurn    = 16'd46080;

  typedef enum logic [CmdW-1:0] {
    CMD_DRAW        = 3'd0,
    CMD_WARP        = 3'd1,
    CMD_TURN        = 3'd2,
    CMD_SET_HEADING = 3'd3,
    CMD_SET_POINT   = 3'd4,
    CMD_MOVE_TO     = 3'd5
  } cmd_e;

  typedef enum logic [0:0] {
    REG_WINDOW_LEFT = 1'b0,
    REG_WINDOW_TOP  = 1'b1
  } reg_e;

  typedef struct packed {
    logic                   done;
    logic signed [RotW-1:0] cos_v;
    logic signed [RotW-1:0] sin_v;
  } rot_res_t;

  function automatic logic signed [ZW-1:0] atan_f(input logic [ItW-1:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740968;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      5'd20: v = 26'sd4;
      5'd21: v = 26'sd2;
      5'd22: v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/tvce_if.sv
// ----------------------------------------------------------------------------
// tvce_if
// Valid/ready channels for commands and segment results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface tvce_cmd_if;
  logic                                  valid;
  logic                                  ready;
  logic [tvce_pkg::CmdW-1:0]             cmd;
  logic signed [tvce_pkg::CoordW-1:0]    step_length;
  logic signed [tvce_pkg::AngW-1:0]      angle_value;
  logic signed [tvce_pkg::CoordW-1:0]    point_x;
  logic signed [tvce_pkg::CoordW-1:0]    point_y;
  modport source (output valid, cmd, step_length, angle_value, point_x, point_y,
                  input ready);
  modport sink (input valid, cmd, step_length, angle_value, point_x, point_y,
                output ready);
endinterface

interface tvce_seg_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  draw;
  logic signed [tvce_pkg::PixW-1:0]      seg_x0;
  logic signed [tvce_pkg::PixW-1:0]      seg_y0;
  logic signed [tvce_pkg::PixW-1:0]      seg_x1;
  logic signed [tvce_pkg::PixW-1:0]      seg_y1;
  logic signed [tvce_pkg::CoordW-1:0]    cur_x;
  logic signed [tvce_pkg::CoordW-1:0]    cur_y;
  modport source (output valid, draw, seg_x0, seg_y0, seg_x1, seg_y1, cur_x, cur_y,
                  input ready);
  modport sink (input valid, draw, seg_x0, seg_y0, seg_x1, seg_y1, cur_x, cur_y,
                output ready);
endinterface
`default_nettype wire

>>> rtl/tvce_cordic.sv
// ----------------------------------------------------------------------------
// tvce_cordic
// Iterative rotation CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tvce_cordic #(
  parameter int unsigned CORDIC_STEPS = tvce_pkg::CordicSteps
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [tvce_pkg::HeadW-1:0]    heading_i,
  output tvce_pkg::rot_res_t                 res_o
);
  localparam int unsigned Steps = (CORDIC_STEPS > tvce_pkg::AtanEntries) ?
                                  tvce_pkg::AtanEntries : CORDIC_STEPS;
  localparam logic [tvce_pkg::ItW-1:0] LastIt = tvce_pkg::ItW'(Steps - 1);

  logic                                busy_q, busy_d, done_q, done_d;
  logic [tvce_pkg::ItW-1:0]            it_q, it_d;
  logic signed [tvce_pkg::RotW-1:0]    x_q, x_d, y_q, y_d, xs, ys;
  logic signed [tvce_pkg::ZW-1:0]      z_q, z_d;
  logic                                flip_q, flip_d;
  logic signed [tvce_pkg::HeadW:0]     hs, fold;

  // fold heading into -90..+90 degrees
  always_comb begin
    hs     = $signed({1'b0, heading_i});
    flip_d = flip_q;
    if (heading_i <= tvce_pkg::QuarterTurn) begin
      fold = hs;
    end else if (heading_i < tvce_pkg::FarLimit) begin
      fold = hs - 17'sd23040;
    end else begin
      fold = hs - 17'sd46080;
    end
    if (start_i) begin
      flip_d = (heading_i > tvce_pkg::QuarterTurn) && (heading_i < tvce_pkg::FarLimit);
    end
  end

  always_comb begin
    xs     = x_q >>> it_q;
    ys     = y_q >>> it_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    it_d   = it_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = tvce_pkg::CordicGain;
      y_d    = '0;
      z_d    = {fold, 9'b0};
      it_d   = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!z_q[tvce_pkg::ZW-1]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - tvce_pkg::atan_f(it_q);
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + tvce_pkg::atan_f(it_q);
      end
      it_d = it_q + 1'b1;
      if (it_q == LastIt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      it_q   <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    flip_q <= flip_d;
  end

  assign res_o.done  = done_q;
  assign res_o.cos_v = flip_q ? -x_q : x_q;
  assign res_o.sin_v = flip_q ? -y_q : y_q;
endmodule
`default_nettype wire

>>> rtl/tvce_smul.sv
// ----------------------------------------------------------------------------
// tvce_smul
// Bit-serial signed multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tvce_smul #(
  parameter int unsigned A_W = tvce_pkg::CoordW,
  parameter int unsigned B_W = tvce_pkg::RotW
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [A_W-1:0]   a_i,
  input  wire logic signed [B_W-1:0]   b_i,
  output logic                         done_o,
  output logic signed [A_W+B_W-1:0]    p_o
);
  localparam int unsigned PW   = A_W + B_W;
  localparam int unsigned CntW = (A_W > 1) ? $clog2(A_W) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(A_W - 1);

  logic                 busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [A_W-1:0]       a_q, a_d;
  logic signed [PW-1:0] b_q, b_d, acc_q, acc_d, addend;

  always_comb begin
    addend = a_q[0] ? b_q : '0;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      b_d    = PW'(b_i);
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // top multiplier bit carries negative weight
      acc_d = (cnt_q == LastCnt) ? acc_q - addend : acc_q + addend;
      a_d   = a_q >> 1;
      b_d   = b_q <<< 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;
endmodule
`default_nettype wire

>>> rtl/turtle_vector_command_engine.sv
// ----------------------------------------------------------------------------
// turtle_vector_command_engine
// Turtle-graphics pen engine: heading, position and screen segment output.
//
//   channel  dir  kind          carries
//   in_i     in   valid/ready   cmd, step_length, angle_value, point_x, point_y
//   out_o    out  valid/ready   draw, seg_x0..seg_y1, cur_x, cur_y
//   apb      in   psel/penable  window_left (0x0), window_top (0x4)
//
// draw move and warp run the CORDIC, one rotation a cycle, then the serial
// multipliers, one length bit a cycle; other commands skip both.
// one command is in flight at a time. reset clears pen, heading and
// window_left and sets window_top to 128000; no clearing pass.
// a finished result waits in the output register while the next command runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module turtle_vector_command_engine #(
  parameter int unsigned CORDIC_STEPS = tvce_pkg::CordicSteps
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  tvce_cmd_if.sink          in_i,
  tvce_seg_if.source        out_o,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  localparam int unsigned CW = tvce_pkg::CoordW;
  localparam logic [tvce_pkg::FracBits-1:0] Half =
    tvce_pkg::FracBits'(1) << (tvce_pkg::FracBits - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ROT  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic signed [CW-1:0] wl_q, wt_q, pen_x_q, pen_y_q, len_q, px_q, py_q;
  logic [tvce_pkg::CmdW-1:0]  cmd_q;
  logic [tvce_pkg::HeadW-1:0] head_q, head_d;
  logic                       acc_in, ld, rot_start, mul_done_c, mul_done_s;
  tvce_pkg::rot_res_t         rot;
  logic signed [tvce_pkg::ProdW-1:0] prod_c, prod_s;
  logic signed [18:0]         hsum;
  logic                       is_step, is_draw;
  logic signed [CW-1:0]       tx, ty;

  logic                       out_valid_q;
  logic                       draw_q;
  logic signed [tvce_pkg::PixW-1:0] sx0_q, sy0_q, sx1_q, sy1_q;

  function automatic logic signed [tvce_pkg::PixW-1:0] to_pix(input logic signed [CW:0] v);
    logic signed [CW:0]           q;
    logic [tvce_pkg::FracBits-1:0] r;
    logic                          rnd;
    logic signed [CW+1:0]          q1;
    q   = v >>> tvce_pkg::FracBits;
    r   = v[tvce_pkg::FracBits-1:0];
    rnd = (r > Half) || ((r == Half) && q[0]);
    q1  = $signed({q[CW], q}) + $signed({{(CW+1){1'b0}}, rnd});
    if (q1 > 26'sd32767) begin
      return 16'sh7fff;
    end else if (q1 < -26'sd32768) begin
      return 16'sh8000;
    end
    return q1[tvce_pkg::PixW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] step_to(input logic signed [CW-1:0] pen,
                                                   input logic signed [tvce_pkg::ProdW-1:0] p);
    logic signed [tvce_pkg::ProdW-1:0] rs;
    logic signed [CW+3:0]              t;
    rs = p + (57'sd1 <<< 29);
    t  = $signed({{4{pen[CW-1]}}, pen}) + $signed({rs[56], rs[56:30]});
    if (t > 28'sd8388607) begin
      return 24'sh7fffff;
    end else if (t < -28'sd8388608) begin
      return 24'sh800000;
    end
    return t[CW-1:0];
  endfunction

  tvce_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .start_i(rot_start), .heading_i(head_q), .res_o(rot)
  );

  tvce_smul #(.A_W(CW), .B_W(tvce_pkg::RotW)) u_mul_cos (
    .clk_i, .rst_ni, .start_i(rot.done), .a_i(len_q), .b_i(rot.cos_v),
    .done_o(mul_done_c), .p_o(prod_c)
  );

  tvce_smul #(.A_W(CW), .B_W(tvce_pkg::RotW)) u_mul_sin (
    .clk_i, .rst_ni, .start_i(rot.done), .a_i(len_q), .b_i(rot.sin_v),
    .done_o(mul_done_s), .p_o(prod_s)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign acc_in     = in_i.valid && in_i.ready;
  assign ld         = (state_q == ST_FIN) && (!out_valid_q || out_o.ready);
  assign rot_start  = acc_in && ((in_i.cmd == tvce_pkg::CMD_DRAW) ||
                                 (in_i.cmd == tvce_pkg::CMD_WARP));

  // heading wrap into 0..360 degrees both ways
  always_comb begin
    head_d = head_q;
    hsum   = (in_i.cmd == tvce_pkg::CMD_TURN) ?
             $signed({3'b0, head_q}) + 19'(in_i.angle_value) : 19'(in_i.angle_value);
    if (hsum < -19'sd46080) begin
      hsum = hsum + 19'sd92160;
    end else if (hsum < 19'sd0) begin
      hsum = hsum + 19'sd46080;
    end else if (hsum >= 19'sd92160) begin
      hsum = hsum - 19'sd92160;
    end else if (hsum >= 19'sd46080) begin
      hsum = hsum - 19'sd46080;
    end
    if (acc_in && ((in_i.cmd == tvce_pkg::CMD_TURN) ||
                   (in_i.cmd == tvce_pkg::CMD_SET_HEADING))) begin
      head_d = hsum[tvce_pkg::HeadW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (acc_in) state_d = rot_start ? ST_ROT : ST_FIN;
      ST_ROT:  if (rot.done) state_d = ST_MUL;
      ST_MUL:  if (mul_done_c) state_d = ST_FIN;
      ST_FIN:  if (ld) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    is_step = (cmd_q == tvce_pkg::CMD_DRAW) || (cmd_q == tvce_pkg::CMD_WARP);
    is_draw = (cmd_q == tvce_pkg::CMD_DRAW) || (cmd_q == tvce_pkg::CMD_MOVE_TO);
    tx = pen_x_q;
    ty = pen_y_q;
    if (is_step) begin
      tx = step_to(pen_x_q, prod_c);
      ty = step_to(pen_y_q, prod_s);
    end else if ((cmd_q == tvce_pkg::CMD_SET_POINT) ||
                 (cmd_q == tvce_pkg::CMD_MOVE_TO)) begin
      tx = px_q;
      ty = py_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      pen_x_q     <= '0;
      pen_y_q     <= '0;
      wl_q        <= '0;
      wt_q        <= 24'sd128000;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      if (ld) begin
        pen_x_q <= tx;
        pen_y_q <= ty;
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == tvce_pkg::REG_WINDOW_TOP) begin
          wt_q <= pwdata[CW-1:0];
        end else begin
          wl_q <= pwdata[CW-1:0];
        end
      end
      if (ld) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      cmd_q <= in_i.cmd;
      len_q <= in_i.step_length;
      px_q  <= in_i.point_x;
      py_q  <= in_i.point_y;
    end
    if (ld) begin
      draw_q <= is_draw;
      sx0_q  <= is_draw ? to_pix($signed({pen_x_q[CW-1], pen_x_q}) - $signed({wl_q[CW-1], wl_q})) : '0;
      sy0_q  <= is_draw ? to_pix($signed({wt_q[CW-1], wt_q}) - $signed({pen_y_q[CW-1], pen_y_q})) : '0;
      sx1_q  <= is_draw ? to_pix($signed({tx[CW-1], tx}) - $signed({wl_q[CW-1], wl_q})) : '0;
      sy1_q  <= is_draw ? to_pix($signed({wt_q[CW-1], wt_q}) - $signed({ty[CW-1], ty})) : '0;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.draw   = draw_q;
  assign out_o.seg_x0 = sx0_q;
  assign out_o.seg_y0 = sy0_q;
  assign out_o.seg_x1 = sx1_q;
  assign out_o.seg_y1 = sy1_q;
  assign out_o.cur_x  = pen_x_q;
  assign out_o.cur_y  = pen_y_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == tvce_pkg::REG_WINDOW_TOP) ? 32'(wt_q) : 32'(wl_q);

`ifndef ASSERT_OFF
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q < tvce_pkg::FullTurn) else $error("heading out of range");
  a_rot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot.done |-> state_q == ST_ROT) else $error("rotation done outside rotate");
  a_mul_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done_c |-> (state_q == ST_MUL) && mul_done_s) else $error("multiply done stray");
  a_no_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !draw_q) |-> (sx0_q == '0) && (sy0_q == '0) && (sx1_q == '0) &&
    (sy1_q == '0)) else $error("segment on non-drawing result");
`endif
endmodule
`default_nettype wire
